### src/hmfn_pkg.sv
// ----------------------------------------------------------------------------
// hmfn_pkg
// shared constants and controller/datapath interface types for the
// heightmap mesh builder with flat normals
// ----------------------------------------------------------------------------
package hmfn_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int HEIGHT_BITS     = 16;
  localparam int COLS_REG_BITS   = 11;
  localparam int ROWS_REG_BITS   = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int ROW_BITS        = 12;
  localparam int MAX_ROWS        = 4096;
  localparam int DIFF_BITS       = HEIGHT_BITS + 1;
  localparam int MAG_BITS        = 16;
  localparam int SQ_BITS         = 2 * MAG_BITS;
  localparam int LEN_BITS        = SQ_BITS + 2;
  localparam int QUO_BITS        = 31;
  localparam int ROOT_BITS       = 16;
  localparam int UNIT_BITS       = 15;
  localparam int NORM_BITS       = 16;
  localparam int UP_MAG          = 256;

  localparam logic CFG_GRID_COLUMNS = 1'b0;
  localparam logic CFG_GRID_ROWS    = 1'b1;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic TRI_A = 1'b0;
  localparam logic TRI_B = 1'b1;

  localparam logic [2:0] VTX_FIRST = 3'd0;
  localparam logic [2:0] VTX_LAST  = 3'd5;

  typedef struct packed {
    logic       accept;
    logic       read;
    logic       update;
    logic       len_step;
    logic       norm_start;
    logic       norm_store;
    logic       tri_sel;
    logic [1:0] comp;
    logic [2:0] vidx;
  } dp_cmd_t;

  typedef struct packed {
    logic cell_ok;
    logic norm_done;
  } dp_sts_t;

endpackage

### src/hmfn_norm.sv
// ----------------------------------------------------------------------------
// hmfn_norm
// iterative unit magnitude: m = round(mag * 16384 / sqrt(len2)) via a
// restoring divide of mag^2 * 2^30 by len2 and a digit-by-digit square root
// ----------------------------------------------------------------------------
module hmfn_norm import hmfn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MAG_BITS-1:0]  mag,
  input  logic [LEN_BITS-1:0]  len2,
  output logic                 done,
  output logic [UNIT_BITS-1:0] m
);

  typedef enum logic [1:0] {P_IDLE, P_DIV, P_ROOT, P_DONE} phase_t;

  phase_t               phase;
  logic [4:0]           cnt;
  logic [LEN_BITS:0]    rem;
  logic [LEN_BITS-1:0]  dreg;
  logic [QUO_BITS-1:0]  quo;
  logic [31:0]          src;
  logic [ROOT_BITS-1:0] root;
  logic [ROOT_BITS:0]   srem;

  logic [SQ_BITS-1:0]   msq;
  logic                 div_ge;
  logic [LEN_BITS:0]    div_diff;
  logic [QUO_BITS-1:0]  quo_next;
  logic [ROOT_BITS+2:0] r2;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] rdiff;
  logic                 root_ge;
  logic [ROOT_BITS:0]   root_inc;

  assign msq      = mag * mag;
  assign div_ge   = rem >= {1'b0, dreg};
  assign div_diff = div_ge ? rem - {1'b0, dreg} : rem;
  assign quo_next = {quo[QUO_BITS-2:0], div_ge};
  assign r2       = {srem, src[31:30]};
  assign trial    = {1'b0, root, 2'b01};
  assign root_ge  = r2 >= trial;
  assign rdiff    = r2 - trial;
  assign root_inc = {1'b0, root} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            rem   <= (LEN_BITS+1)'(msq);
            dreg  <= len2;
            quo   <= '0;
            cnt   <= 5'(QUO_BITS - 1);
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          rem <= {div_diff[LEN_BITS-1:0], 1'b0};
          quo <= quo_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            src   <= {1'b0, quo_next};
            root  <= '0;
            srem  <= '0;
            cnt   <= 5'(ROOT_BITS - 1);
            phase <= P_ROOT;
          end
        end
        P_ROOT: begin
          srem <= root_ge ? rdiff[ROOT_BITS:0] : r2[ROOT_BITS:0];
          root <= {root[ROOT_BITS-2:0], root_ge};
          src  <= {src[29:0], 2'b00};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            phase <= P_DONE;
          end
        end
        P_DONE: begin
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  assign done = phase == P_DONE;
  assign m    = root_inc[UNIT_BITS:1];

endmodule

### src/hmfn_dp.sv
// ----------------------------------------------------------------------------
// hmfn_dp
// datapath: config registers, line store, counters, cell corners, length
// accumulation, normal storage and vertex selection
// ----------------------------------------------------------------------------
module hmfn_dp import hmfn_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int COL_BITS = $clog2(MAX_COLUMNS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [HEIGHT_BITS-1:0] height_sample,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  output logic [COL_BITS-1:0]           pos_x,
  output logic signed [HEIGHT_BITS-1:0] pos_y,
  output logic [ROW_BITS-1:0]           pos_z,
  output logic signed [NORM_BITS-1:0]   norm_x,
  output logic signed [NORM_BITS-1:0]   norm_y,
  output logic signed [NORM_BITS-1:0]   norm_z,
  output logic                          last_vertex
);

  logic [COLS_REG_BITS-1:0] grid_columns;
  logic [ROWS_REG_BITS-1:0] grid_rows;
  logic [COL_BITS:0]        cols_eff;
  logic [ROWS_REG_BITS-1:0] rows_eff;

  logic [COL_BITS-1:0]      col_q;
  logic [ROW_BITS-1:0]      row_q;
  logic [COL_BITS-1:0]      c_eff;
  logic [ROW_BITS-1:0]      r_eff;
  logic [COL_BITS-1:0]      cx;
  logic [ROW_BITS-1:0]      rz;
  logic [COL_BITS:0]        cx_inc;
  logic [ROW_BITS:0]        rz_inc;

  logic signed [HEIGHT_BITS-1:0] mem [MAX_COLUMNS];
  logic signed [HEIGHT_BITS-1:0] s_q;
  logic signed [HEIGHT_BITS-1:0] above_q;
  logic signed [HEIGHT_BITS-1:0] left_cur;
  logic signed [HEIGHT_BITS-1:0] left_prev;
  logic signed [HEIGHT_BITS-1:0] h00, h01, h10, h11;

  logic signed [DIFF_BITS-1:0] dx, dz, adx, adz;
  logic [MAG_BITS-1:0]         mag_sel;
  logic                        neg_sel;
  logic [SQ_BITS-1:0]          sq;
  logic [LEN_BITS-1:0]         len_q;
  logic                        norm_done;
  logic [UNIT_BITS-1:0]        unit_m;
  logic signed [NORM_BITS-1:0] unit_val;
  logic signed [NORM_BITS-1:0] na_x, na_y, na_z, nb_x, nb_y, nb_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLS_REG_BITS'(2);
      grid_rows    <= ROWS_REG_BITS'(2);
    end else if (cfg_write) begin
      if (cfg_index == CFG_GRID_COLUMNS) begin
        grid_columns <= cfg_data[COLS_REG_BITS-1:0];
      end else begin
        grid_rows <= cfg_data[ROWS_REG_BITS-1:0];
      end
    end
  end

  always_comb begin
    priority if (grid_columns < COLS_REG_BITS'(2)) begin
      cols_eff = (COL_BITS+1)'(2);
    end else if (32'(grid_columns) > MAX_COLUMNS) begin
      cols_eff = (COL_BITS+1)'(MAX_COLUMNS);
    end else begin
      cols_eff = (COL_BITS+1)'(grid_columns);
    end
    priority if (grid_rows < ROWS_REG_BITS'(2)) begin
      rows_eff = ROWS_REG_BITS'(2);
    end else if (grid_rows > ROWS_REG_BITS'(MAX_ROWS)) begin
      rows_eff = ROWS_REG_BITS'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
  end

  assign c_eff  = ({1'b0, col_q} >= cols_eff) ? '0 : col_q;
  assign r_eff  = ({1'b0, row_q} >= rows_eff) ? '0 : row_q;
  assign cx_inc = {1'b0, cx} + (COL_BITS+1)'(1);
  assign rz_inc = {1'b0, rz} + (ROW_BITS+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q     <= '0;
      row_q     <= '0;
      left_cur  <= '0;
      left_prev <= '0;
    end else if (cmd.update) begin
      left_cur  <= s_q;
      left_prev <= above_q;
      if (cx_inc >= cols_eff) begin
        col_q <= '0;
        row_q <= (rz_inc >= rows_eff) ? '0 : rz_inc[ROW_BITS-1:0];
      end else begin
        col_q <= cx_inc[COL_BITS-1:0];
        row_q <= rz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_q <= height_sample;
      cx  <= c_eff;
      rz  <= r_eff;
    end
    if (cmd.update) begin
      h00 <= left_prev;
      h01 <= left_cur;
      h10 <= above_q;
      h11 <= s_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      above_q <= mem[cx];
    end
    if (cmd.update) begin
      mem[cx] <= s_q;
    end
  end

  assign sts.cell_ok   = (cx != '0) && (rz != '0);
  assign sts.norm_done = norm_done;

  always_comb begin
    if (cmd.tri_sel == TRI_A) begin
      dx = DIFF_BITS'(h10) - DIFF_BITS'(h00);
      dz = DIFF_BITS'(h01) - DIFF_BITS'(h00);
    end else begin
      dx = DIFF_BITS'(h11) - DIFF_BITS'(h01);
      dz = DIFF_BITS'(h11) - DIFF_BITS'(h10);
    end
    adx = dx[DIFF_BITS-1] ? -dx : dx;
    adz = dz[DIFF_BITS-1] ? -dz : dz;
    unique case (cmd.comp)
      COMP_X: begin
        mag_sel = adx[MAG_BITS-1:0];
        neg_sel = dx[DIFF_BITS-1];
      end
      COMP_Y: begin
        mag_sel = MAG_BITS'(UP_MAG);
        neg_sel = 1'b1;
      end
      COMP_Z: begin
        mag_sel = adz[MAG_BITS-1:0];
        neg_sel = dz[DIFF_BITS-1];
      end
      default: begin
        mag_sel = '0;
        neg_sel = 1'b0;
      end
    endcase
  end

  assign sq = mag_sel * mag_sel;

  always_ff @(posedge clk) begin
    if (cmd.len_step) begin
      len_q <= (cmd.comp == COMP_X) ? LEN_BITS'(sq) : len_q + LEN_BITS'(sq);
    end
  end

  hmfn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_start),
    .mag   (mag_sel),
    .len2  (len_q),
    .done  (norm_done),
    .m     (unit_m)
  );

  assign unit_val = neg_sel ? -NORM_BITS'(unit_m) : NORM_BITS'(unit_m);

  always_ff @(posedge clk) begin
    if (cmd.norm_store) begin
      unique case ({cmd.tri_sel, cmd.comp})
        {TRI_A, COMP_X}: na_x <= unit_val;
        {TRI_A, COMP_Y}: na_y <= unit_val;
        {TRI_A, COMP_Z}: na_z <= unit_val;
        {TRI_B, COMP_X}: nb_x <= unit_val;
        {TRI_B, COMP_Y}: nb_y <= unit_val;
        {TRI_B, COMP_Z}: nb_z <= unit_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_vertex = cmd.vidx == VTX_LAST;
    unique case (cmd.vidx)
      3'd1: begin
        pos_x = cx - COL_BITS'(1);
        pos_y = h01;
        pos_z = rz;
      end
      3'd2, 3'd5: begin
        pos_x = cx;
        pos_y = h10;
        pos_z = rz - ROW_BITS'(1);
      end
      3'd3: begin
        pos_x = cx - COL_BITS'(1);
        pos_y = h01;
        pos_z = rz;
      end
      3'd4: begin
        pos_x = cx;
        pos_y = h11;
        pos_z = rz;
      end
      default: begin
        pos_x = cx - COL_BITS'(1);
        pos_y = h00;
        pos_z = rz - ROW_BITS'(1);
      end
    endcase
    if (cmd.vidx >= 3'd3 && cmd.vidx <= VTX_LAST) begin
      norm_x = nb_x;
      norm_y = nb_y;
      norm_z = nb_z;
    end else begin
      norm_x = na_x;
      norm_y = na_y;
      norm_z = na_z;
    end
  end

endmodule

### src/hmfn_ctrl.sv
// ----------------------------------------------------------------------------
// hmfn_ctrl
// controller: sequences read, update, normal computation and the six
// vertex outputs of each closed cell
// ----------------------------------------------------------------------------
module hmfn_ctrl import hmfn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_UPD, S_LEN, S_NSTART, S_NWAIT, S_EMIT
  } state_t;

  state_t     state;
  logic       tri_sel;
  logic [1:0] comp;
  logic [2:0] vidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tri_sel <= TRI_A;
      comp    <= COMP_X;
      vidx    <= VTX_FIRST;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          tri_sel <= TRI_A;
          comp    <= COMP_X;
          state   <= sts.cell_ok ? S_LEN : S_IDLE;
        end
        S_LEN: begin
          if (comp == COMP_Z) begin
            comp  <= COMP_X;
            state <= S_NSTART;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_NSTART: begin
          state <= S_NWAIT;
        end
        S_NWAIT: begin
          if (sts.norm_done) begin
            if (comp == COMP_Z) begin
              comp <= COMP_X;
              if (tri_sel == TRI_B) begin
                vidx  <= VTX_FIRST;
                state <= S_EMIT;
              end else begin
                tri_sel <= TRI_B;
                state   <= S_LEN;
              end
            end else begin
              comp  <= comp + 2'd1;
              state <= S_NSTART;
            end
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (vidx == VTX_LAST) begin
              state <= S_IDLE;
            end else begin
              vidx <= vidx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_EMIT;

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == S_IDLE) && in_valid;
    cmd.read       = state == S_READ;
    cmd.update     = state == S_UPD;
    cmd.len_step   = state == S_LEN;
    cmd.norm_start = state == S_NSTART;
    cmd.norm_store = (state == S_NWAIT) && sts.norm_done;
    cmd.tri_sel    = tri_sel;
    cmd.comp       = comp;
    cmd.vidx       = vidx;
  end

  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while vertices pending");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_READ)
    else $error("accepted item did not start line store read");

  a_vidx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> vidx <= VTX_LAST)
    else $error("vertex index out of range");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    sts.norm_done |-> state == S_NWAIT)
    else $error("normal unit finished outside wait");

endmodule

### src/heightmap_mesh_with_flat_normals_top.sv
// ----------------------------------------------------------------------------
// heightmap_mesh_with_flat_normals_top
// streams height samples and emits six vertices with flat normals per
// closed grid cell
//
// channel   direction  handshake            payload
// cfg       in         cfg_write            cfg_index, cfg_data
// in        in         in_valid / in_stall  height_sample
// out       out        out_valid / out_stall pos_x..pos_z, norm_x..z, last_vertex
//
// an item closing no cell is only read and updated; one closing a cell also
// computes the normals of two triangles, three components each, every component
// through the shared normal unit (31 divide steps and 16 square root steps),
// then emits its vertices. one item is in flight at a time. reset clears the
// counters, neighbor heights and registers; the line store needs no clearing.
// ----------------------------------------------------------------------------
module heightmap_mesh_with_flat_normals_top import hmfn_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [CFG_DATA_BITS-1:0]           cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [HEIGHT_BITS-1:0]      height_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [$clog2(MAX_COLUMNS)-1:0]     pos_x,
  output logic signed [HEIGHT_BITS-1:0]      pos_y,
  output logic [ROW_BITS-1:0]                pos_z,
  output logic signed [NORM_BITS-1:0]        norm_x,
  output logic signed [NORM_BITS-1:0]        norm_y,
  output logic signed [NORM_BITS-1:0]        norm_z,
  output logic                               last_vertex
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hmfn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hmfn_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .height_sample (height_sample),
    .cmd           (cmd),
    .sts           (sts),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .norm_x        (norm_x),
    .norm_y        (norm_y),
    .norm_z        (norm_z),
    .last_vertex   (last_vertex)
  );

endmodule

### tb/sv/hmfn_mesh_checker.sv
// ----------------------------------------------------------------------------
// hmfn_mesh_checker
// watches the config port and both item channels of the heightmap mesh
// builder, predicts the six vertices and flat normals of every closed cell,
// and compares each output item in order against the oldest prediction
// ----------------------------------------------------------------------------
module hmfn_mesh_checker import hmfn_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [HEIGHT_BITS-1:0] height_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [9:0]                    pos_x,
  input  logic signed [HEIGHT_BITS-1:0] pos_y,
  input  logic [ROW_BITS-1:0]           pos_z,
  input  logic signed [NORM_BITS-1:0]   norm_x,
  input  logic signed [NORM_BITS-1:0]   norm_y,
  input  logic signed [NORM_BITS-1:0]   norm_z,
  input  logic                          last_vertex,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  x;
    logic [15:0] y;
    logic [11:0] z;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
  } vertex_t;

  vertex_t              vertex_q[$];
  logic [COLS_REG_BITS-1:0] grid_cols;
  logic [ROWS_REG_BITS-1:0] grid_rows;
  int                   line_store[MAX_COLUMNS_DEF];
  int                   col_cnt;
  int                   row_cnt;
  int                   left_cur;
  int                   left_prev;

  // largest m with (2m-1)^2 * len2 <= mag^2 * 2^30
  function automatic longint unsigned unit_q14(input longint unsigned mag,
                                               input longint unsigned len2);
    longint unsigned rhs, lo, hi, mid, d;
    rhs = (mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void flat_normal(input longint vx, input longint vy, input longint vz,
                                      output logic [15:0] n[3]);
    longint          v[3];
    longint unsigned m[3];
    longint unsigned big, len2, u;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    while (big > 64'hFFFF) begin
      big >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    for (int i = 0; i < 3; i++) begin
      u = (len2 == 0) ? 0 : unit_q14(m[i], len2);
      if (v[i] < 0) u = 0 - u;
      n[i] = u[15:0];
    end
  endfunction

  function automatic vertex_t make_vertex(input int x, input int h, input int z,
                                          input logic [15:0] n[3], input logic last);
    vertex_t vtx;
    vtx.x = x[9:0];
    vtx.y = h[15:0];
    vtx.z = z[11:0];
    vtx.nx = n[0];
    vtx.ny = n[1];
    vtx.nz = n[2];
    vtx.last = last;
    return vtx;
  endfunction

  task automatic mesh_sample(input logic signed [15:0] h);
    int cols, rows, c, r, s, above, h00, h01, h10, h11;
    logic [15:0] na[3];
    logic [15:0] nb[3];
    cols = grid_cols;
    rows = grid_rows;
    if (cols < 2) cols = 2;
    if (cols > MAX_COLUMNS_DEF) cols = MAX_COLUMNS_DEF;
    if (rows < 2) rows = 2;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    c = col_cnt;
    r = row_cnt;
    if (c >= cols) c = 0;
    if (r >= rows) r = 0;
    s = h;
    above = line_store[c];
    if (r >= 1 && c >= 1) begin
      h00 = left_prev;
      h01 = left_cur;
      h10 = above;
      h11 = s;
      flat_normal(h10 - h00, -UP_MAG, h01 - h00, na);
      flat_normal(h11 - h01, -UP_MAG, h11 - h10, nb);
      vertex_q.insert(vertex_q.size(), make_vertex(c - 1, h00, r - 1, na, 1'b0));
      vertex_q.insert(vertex_q.size(), make_vertex(c - 1, h01, r, na, 1'b0));
      vertex_q.insert(vertex_q.size(), make_vertex(c, h10, r - 1, na, 1'b0));
      vertex_q.insert(vertex_q.size(), make_vertex(c - 1, h01, r, nb, 1'b0));
      vertex_q.insert(vertex_q.size(), make_vertex(c, h11, r, nb, 1'b0));
      vertex_q.insert(vertex_q.size(), make_vertex(c, h10, r - 1, nb, 1'b1));
    end
    line_store[c] = s;
    left_prev = above;
    left_cur = s;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst) begin
      errors = 0;
      grid_cols = 2;
      grid_rows = 2;
      col_cnt = 0;
      row_cnt = 0;
      left_cur = 0;
      left_prev = 0;
      vertex_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_GRID_COLUMNS) grid_cols = cfg_data[COLS_REG_BITS-1:0];
        else grid_rows = cfg_data[ROWS_REG_BITS-1:0];
      end
      if (in_valid && !in_stall) mesh_sample(height_sample);
      if (out_valid && !out_stall) begin
        got = {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last_vertex};
        if (vertex_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected vertex, expected none, actual %h", $time, got);
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: vertex mismatch expected x=%0d y=%h z=%0d n=%h,%h,%h last=%b",
                     $time, want.x, want.y, want.z, want.nx, want.ny, want.nz, want.last);
            $display("%0t:                 actual   x=%0d y=%h z=%0d n=%h,%h,%h last=%b",
                     $time, got.x, got.y, got.z, got.nx, got.ny, got.nz, got.last);
          end
        end
      end
    end
    pending = vertex_q.size();
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives height samples and grid size writes into the heightmap mesh
// builder under random sender bursts and receiver stalls; the checker
// predicts every vertex and the verdict follows its error count
// ----------------------------------------------------------------------------
module tb_top import hmfn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic                          cfg_index = CFG_GRID_COLUMNS;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [HEIGHT_BITS-1:0] height_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [9:0]                    pos_x;
  logic signed [HEIGHT_BITS-1:0] pos_y;
  logic [ROW_BITS-1:0]           pos_z;
  logic signed [NORM_BITS-1:0]   norm_x;
  logic signed [NORM_BITS-1:0]   norm_y;
  logic signed [NORM_BITS-1:0]   norm_z;
  logic                          last_vertex;
  int                            errors;
  int                            pending;
  int                            burst_left = 0;
  int                            rx_cycle = 0;

  heightmap_mesh_with_flat_normals_top dut (.*);

  hmfn_mesh_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: changing stall patterns plus one long hold-off
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle >= 20000 && rx_cycle < 22000) out_stall <= 1'b1;
    else begin
      case (rx_cycle[10:9])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 1) == 0);
        2'd2: out_stall <= (rx_cycle[1:0] == 2'd0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic push_height(input logic [15:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    height_sample <= h;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_heights(input int n);
    for (int i = 0; i < n; i++) push_height(pick_height());
  endtask

  initial begin
    int items;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x3 frame of extremes
    write_reg(CFG_GRID_COLUMNS, 3);
    write_reg(CFG_GRID_ROWS, 3);
    push_height(16'h7FFF); push_height(16'h8000); push_height(16'h0000);
    push_height(16'h8000); push_height(16'h7FFF); push_height(16'h8000);
    push_height(16'h0000); push_height(16'h7FFF); push_height(16'hFFFF);
    go_quiet();

    // flat cell and below-range sizes (clamp to 2)
    write_reg(CFG_GRID_COLUMNS, 1);
    write_reg(CFG_GRID_ROWS, 0);
    push_height(16'h0100); push_height(16'h0100);
    push_height(16'h0100); push_height(16'h0100);
    push_height(16'h0001); push_height(16'hFF00);
    push_height(16'h5555); push_height(16'hAAAA);
    go_quiet();

    // above-range sizes: a long first row, no cells and no early wrap
    write_reg(CFG_GRID_COLUMNS, 2047);
    write_reg(CFG_GRID_ROWS, 8191);
    random_heights(40);
    go_quiet();

    // mid-frame shrink: counters wrap
    write_reg(CFG_GRID_COLUMNS, 4);
    write_reg(CFG_GRID_ROWS, 3);
    random_heights(30);
    go_quiet();

    items = 0;
    while (items < 300) begin
      write_reg(CFG_GRID_COLUMNS, $urandom_range(2, 7));
      write_reg(CFG_GRID_ROWS, ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(2, 6));
      n = $urandom_range(20, 60);
      random_heights(n);
      items += n;
      go_quiet();
    end

    repeat (400) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
